FILE: rtl/core/pressure_temp_compensation_macros.svh
// Assertion helpers shared by the compensation pipeline.
`ifndef PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS
`define PTC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pipeline check failed");
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pipeline check failed");
`else
`define PTC_ASSERT_SAME(lbl, ante, cons)
`define PTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/ptc_pkg.sv
package ptc_pkg;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

   localparam logic [1:0] CSR_TEMP_CALIB    = 2'd0;
   localparam logic [1:0] CSR_PRESS_CALIB_A = 2'd1;
   localparam logic [1:0] CSR_PRESS_CALIB_B = 2'd2;
   localparam logic [1:0] CSR_PRESS_CALIB_C = 2'd3;

   localparam logic [19:0] RAW_MID        = 20'h80000;
   localparam logic [32:0] T_FINE_OFFSET  = 33'd128000;
   localparam logic [20:0] PRESS_FULL     = 21'd1048576;
   localparam logic [63:0] CAL_BIAS       = 64'h0000_8000_0000_0000;
   localparam logic signed [16:0] SCALE_3125 = 17'sd3125;

   typedef struct packed {
      logic        invalid;
      logic        zero_div;
      logic [31:0] temp;
      logic [19:0] press_sample;
   } side_type;

   typedef struct packed {
      logic     negate;
      side_type side;
   } div_tag_type;

   typedef struct packed {
      logic [49:0] lo;
      logic [31:0] hi;
   } pp_type;

   // Splits a 64 by 17 bit product, kept modulo 2^64, into two narrow partial products.
   function automatic pp_type pp_mul(input logic [63:0] x, input logic signed [16:0] c);
      pp_type             r;
      logic signed [49:0] lo;
      logic [31:0]        hi;
      lo   = $signed({1'b0, x[31:0]}) * c;
      hi   = x[63:32] * {{15{c[16]}}, c};
      r.lo = lo;
      r.hi = hi;
      return r;
   endfunction

   function automatic logic [63:0] pp_sum(input pp_type p);
      return {p.hi, 32'd0} + {{14{p.lo[49]}}, p.lo};
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

endpackage

FILE: rtl/core/ptc_div.sv
module ptc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [63:0]          in_dividend,
   input  logic [30:0]          in_divisor,
   input  ptc_pkg::div_tag_type in_tag,
   output logic                 out_valid,
   output logic [63:0]          out_quotient,
   output ptc_pkg::div_tag_type out_tag
);
   import ptc_pkg::*;

   localparam int STEPS = 64;

   logic [30:0]  rem_ff [1:STEPS];
   logic [63:0]  dq_ff  [1:STEPS];
   logic [30:0]  dvs_ff [1:STEPS];
   div_tag_type  tag_ff [1:STEPS];
   logic         v_ff   [1:STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [30:0] rem_src;
      logic [63:0] dq_src;
      logic [30:0] dvs_src;
      div_tag_type tag_src;
      logic        v_src;
      logic [31:0] trial;
      logic [31:0] diff;
      logic        take;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign dq_src  = in_dividend;
         assign dvs_src = in_divisor;
         assign tag_src = in_tag;
         assign v_src   = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[k];
         assign dq_src  = dq_ff[k];
         assign dvs_src = dvs_ff[k];
         assign tag_src = tag_ff[k];
         assign v_src   = v_ff[k];
      end

      assign trial = {rem_src, dq_src[63]};
      assign diff  = trial - {1'b0, dvs_src};
      assign take  = trial >= {1'b0, dvs_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            v_ff[k+1] <= v_src;
         end
         if (advance) begin
            rem_ff[k+1] <= take ? diff[30:0] : trial[30:0];
            dq_ff[k+1]  <= {dq_src[62:0], take};
            dvs_ff[k+1] <= dvs_src;
            tag_ff[k+1] <= tag_src;
         end
      end
   end

   assign out_valid    = v_ff[STEPS];
   assign out_quotient = dq_ff[STEPS];
   assign out_tag      = tag_ff[STEPS];

endmodule

FILE: rtl/core/pressure_temp_compensation.sv
// Channel  Direction  Handshake          Word
// req      in         req_valid/stall    raw temperature, raw pressure
// rsp      out        rsp_valid/stall    scaled temperature, Q24.8 pressure, status
// csr      in         csr_write          calibration register index and data
//
// One word is taken every cycle while no result waits under rsp_stall; from acceptance to the
// result register a word passes 12 stages of compensation arithmetic, 64 stages of the
// restoring divider (one quotient bit per stage) and 7 stages after it.
// Reset clears the valid bits and the calibration registers.
// While a result waits under rsp_stall the whole pipeline holds.
`include "pressure_temp_compensation_macros.svh"

module pressure_temp_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_temperature_scaled,
   output logic signed [31:0] rsp_pressure_q24_8,
   output logic [1:0]         rsp_status,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import ptc_pkg::*;

   localparam int PRE = 12;
   localparam int POST = 6;

   logic [47:0] temp_calib_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_c_ff;

   logic adv;

   logic [PRE:1]  pre_v_ff;
   side_type      pre_side_ff [1:PRE];
   side_type      pre_side_in [1:PRE];
   logic [POST:1] post_v_ff;
   side_type      post_side_ff [1:POST];

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_temp_ff;
   logic signed [31:0] rsp_press_ff;
   logic [1:0]         rsp_status_ff;

   logic [15:0] t1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [15:0] p1;

   logic signed [17:0] s1_d1_ff, s1_d1_in;
   logic signed [16:0] s1_d2_ff, s1_d2_in;
   logic [31:0] s2_m1_ff, s2_dd_ff;
   logic signed [33:0] s2_m1_full, s2_dd_full;
   logic signed [20:0] s3_v1_ff;
   logic [31:0] s3_m3_ff;
   logic signed [35:0] s3_m3_full;
   logic signed [19:0] s3_x;
   logic [31:0] s4_tfine_ff;
   logic signed [32:0] s5_a_ff;
   logic [31:0] s5_tout;
   logic [63:0] s6_aa_ff;
   logic signed [65:0] s6_aa_full;
   logic signed [48:0] s6_ap5_ff, s6_ap2_ff, s6_ap5_in, s6_ap2_in;
   pp_type s7_pp6_ff, s7_pp3_ff;
   logic signed [48:0] s7_ap5_ff, s7_ap2_ff;
   logic [63:0] s8_b_ff, s8_c_ff;
   pp_type s9_pp1_ff;
   logic [63:0] s9_nb_ff;
   logic [20:0] s9_pdiff;
   logic [30:0] s10_den_ff;
   pp_type s10_ppn_ff;
   logic [63:0] s11_num_ff;
   logic [30:0] s11_den_ff;
   logic [63:0] s12_ma_ff;
   logic [30:0] s12_mb_ff;
   logic        s12_neg_ff;

   logic        div_v;
   logic [63:0] div_q;
   div_tag_type div_tag;

   logic [63:0] q1_p_ff;
   logic [63:0] q2_p_ff, q2_ll_ff;
   logic [31:0] q2_hl_ff;
   pp_type      q2_pp8_ff;
   logic [63:0] q2_ps;
   logic [63:0] q3_p_ff, q3_ps2_ff, q3_b2_ff;
   logic [63:0] q4_p_ff, q4_b2_ff;
   pp_type      q4_pp9_ff;
   logic [63:0] q5_p_ff, q5_b2_ff, q5_a2_ff;
   logic [63:0] q6_r_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign t1 = temp_calib_ff[15:0];
   assign t2 = temp_calib_ff[31:16];
   assign t3 = temp_calib_ff[47:32];
   assign p1 = press_a_ff[15:0];
   assign p2 = press_a_ff[31:16];
   assign p3 = press_a_ff[47:32];
   assign p4 = press_a_ff[63:48];
   assign p5 = press_b_ff[15:0];
   assign p6 = press_b_ff[31:16];
   assign p7 = press_b_ff[47:32];
   assign p8 = press_b_ff[63:48];
   assign p9 = press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_c_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TEMP_CALIB:    temp_calib_ff <= csr_data[47:0];
            CSR_PRESS_CALIB_A: press_a_ff    <= csr_data;
            CSR_PRESS_CALIB_B: press_b_ff    <= csr_data;
            CSR_PRESS_CALIB_C: press_c_ff    <= csr_data[15:0];
            default:           press_c_ff    <= press_c_ff;
         endcase
      end
   end

   always_comb begin
      s1_d1_in   = {1'b0, req_raw_temperature[19:3]} - {1'b0, t1, 1'b0};
      s1_d2_in   = {1'b0, req_raw_temperature[19:4]} - {1'b0, t1};
      s2_m1_full = s1_d1_ff * t2;
      s2_dd_full = s1_d2_ff * s1_d2_ff;
      s3_x       = s2_dd_ff[31:12];
      s3_m3_full = s3_x * t3;
      s5_tout    = {s4_tfine_ff[29:0], 2'b00} + s4_tfine_ff + 32'd128;
      s6_aa_full = s5_a_ff * s5_a_ff;
      s6_ap5_in  = s5_a_ff * p5;
      s6_ap2_in  = s5_a_ff * p2;
      s9_pdiff   = PRESS_FULL - {1'b0, pre_side_ff[8].press_sample};
      q2_ps      = asr64(q1_p_ff, 13);

      for (int k = 2; k <= PRE; k++) begin
         pre_side_in[k] = pre_side_ff[k-1];
      end
      pre_side_in[1].invalid   = req_raw_temperature == '0 || req_raw_temperature == RAW_MID ||
                                 req_raw_pressure == '0 || req_raw_pressure == RAW_MID;
      pre_side_in[1].zero_div  = 1'b0;
      pre_side_in[1].temp      = '0;
      pre_side_in[1].press_sample = req_raw_pressure;
      pre_side_in[5].temp      = s5_tout;
      pre_side_in[11].zero_div = s10_den_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff     <= '0;
         post_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_v_ff     <= {pre_v_ff[PRE-1:1], req_valid};
         post_v_ff    <= {post_v_ff[POST-1:1], div_v};
         rsp_valid_ff <= post_v_ff[POST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= PRE; k++) begin
            pre_side_ff[k] <= pre_side_in[k];
         end
         post_side_ff[1] <= div_tag.side;
         for (int k = 2; k <= POST; k++) begin
            post_side_ff[k] <= post_side_ff[k-1];
         end

         s1_d1_ff    <= s1_d1_in;
         s1_d2_ff    <= s1_d2_in;
         s2_m1_ff    <= s2_m1_full[31:0];
         s2_dd_ff    <= s2_dd_full[31:0];
         s3_v1_ff    <= s2_m1_ff[31:11];
         s3_m3_ff    <= s3_m3_full[31:0];
         s4_tfine_ff <= {{11{s3_v1_ff[20]}}, s3_v1_ff} + {{14{s3_m3_ff[31]}}, s3_m3_ff[31:14]};
         s5_a_ff     <= {s4_tfine_ff[31], s4_tfine_ff} - T_FINE_OFFSET;
         s6_aa_ff    <= s6_aa_full[63:0];
         s6_ap5_ff   <= s6_ap5_in;
         s6_ap2_ff   <= s6_ap2_in;
         s7_pp6_ff   <= pp_mul(s6_aa_ff, {p6[15], p6});
         s7_pp3_ff   <= pp_mul(s6_aa_ff, {p3[15], p3});
         s7_ap5_ff   <= s6_ap5_ff;
         s7_ap2_ff   <= s6_ap2_ff;
         s8_b_ff     <= pp_sum(s7_pp6_ff) + ({{15{s7_ap5_ff[48]}}, s7_ap5_ff} << 17)
                        + ({{48{p4[15]}}, p4} << 35);
         s8_c_ff     <= asr64(pp_sum(s7_pp3_ff), 8) + ({{15{s7_ap2_ff[48]}}, s7_ap2_ff} << 12)
                        + CAL_BIAS;
         s9_pp1_ff   <= pp_mul(s8_c_ff, {1'b0, p1});
         s9_nb_ff    <= {12'd0, s9_pdiff, 31'd0} - s8_b_ff;
         s10_den_ff  <= 31'(pp_sum(s9_pp1_ff) >> 33);
         s10_ppn_ff  <= pp_mul(s9_nb_ff, SCALE_3125);
         s11_num_ff  <= pp_sum(s10_ppn_ff);
         s11_den_ff  <= s10_den_ff;
         s12_neg_ff  <= s11_num_ff[63] ^ s11_den_ff[30];
         s12_ma_ff   <= s11_num_ff[63] ? 64'd0 - s11_num_ff : s11_num_ff;
         s12_mb_ff   <= s11_den_ff[30] ? 31'd0 - s11_den_ff : s11_den_ff;

         q1_p_ff   <= div_tag.negate ? 64'd0 - div_q : div_q;
         q2_p_ff   <= q1_p_ff;
         q2_ll_ff  <= q2_ps[31:0] * q2_ps[31:0];
         q2_hl_ff  <= q2_ps[63:32] * q2_ps[31:0];
         q2_pp8_ff <= pp_mul(q1_p_ff, {p8[15], p8});
         q3_p_ff   <= q2_p_ff;
         q3_ps2_ff <= q2_ll_ff + {q2_hl_ff[30:0], 33'd0};
         q3_b2_ff  <= asr64(pp_sum(q2_pp8_ff), 19);
         q4_p_ff   <= q3_p_ff;
         q4_b2_ff  <= q3_b2_ff;
         q4_pp9_ff <= pp_mul(q3_ps2_ff, {p9[15], p9});
         q5_p_ff   <= q4_p_ff;
         q5_b2_ff  <= q4_b2_ff;
         q5_a2_ff  <= asr64(pp_sum(q4_pp9_ff), 25);
         q6_r_ff   <= asr64(q5_p_ff + q5_a2_ff + q5_b2_ff, 8) + ({{48{p7[15]}}, p7} << 4);

         priority if (post_side_ff[POST].invalid) begin
            rsp_temp_ff   <= '0;
            rsp_press_ff  <= '0;
            rsp_status_ff <= STATUS_INVALID;
         end else if (post_side_ff[POST].zero_div) begin
            rsp_temp_ff   <= post_side_ff[POST].temp;
            rsp_press_ff  <= '0;
            rsp_status_ff <= STATUS_ZERO_DIV;
         end else begin
            rsp_temp_ff   <= post_side_ff[POST].temp;
            rsp_status_ff <= STATUS_OK;
            priority if ($signed(q6_r_ff) < -64'sd2147483648) begin
               rsp_press_ff <= 32'sh8000_0000;
            end else if ($signed(q6_r_ff) > 64'sd2147483647) begin
               rsp_press_ff <= 32'sh7FFF_FFFF;
            end else begin
               rsp_press_ff <= q6_r_ff[31:0];
            end
         end
      end
   end

   ptc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (adv),
      .in_valid     (pre_v_ff[PRE]),
      .in_dividend  (s12_ma_ff),
      .in_divisor   (s12_mb_ff),
      .in_tag       ({s12_neg_ff, pre_side_ff[PRE]}),
      .out_valid    (div_v),
      .out_quotient (div_q),
      .out_tag      (div_tag)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_scaled = rsp_temp_ff;
   assign rsp_pressure_q24_8     = rsp_press_ff;
   assign rsp_status             = rsp_status_ff;

   `PTC_ASSERT_SAME(a_invalid_zero, rsp_valid_ff && rsp_status_ff == STATUS_INVALID, rsp_temp_ff == 32'sd0 && rsp_press_ff == 32'sd0)
   `PTC_ASSERT_SAME(a_zero_div_press, rsp_valid_ff && rsp_status_ff == STATUS_ZERO_DIV, rsp_press_ff == 32'sd0)
   `PTC_ASSERT_NEXT(a_enter, req_valid && !req_stall, pre_v_ff[1])
   `PTC_ASSERT_NEXT(a_freeze, !adv, pre_v_ff == $past(pre_v_ff) && post_v_ff == $past(post_v_ff))

endmodule
